// ===== rtl/core/pn2d_pkg.sv =====
// shared constants and arithmetic helpers for 2-d gradient noise
package pn2d_pkg;

  localparam logic [31:0] HashMulA = 32'd3284157443;
  localparam logic [31:0] HashMulB = 32'd1911520717;
  localparam logic [31:0] HashMulC = 32'd2048419325;

  localparam int unsigned OffW = 18;  // signed corner offset, -65536..65535
  localparam int unsigned GrdW = 16;  // signed gradient component, q14
  localparam int unsigned DotW = 20;  // signed dot product, q16
  localparam int unsigned FadW = 17;  // fade weight, 0..65536

  function automatic logic [31:0] rot16(input logic [31:0] v);
    rot16 = {v[15:0], v[31:16]};
  endfunction

  // position inside the quarter wave, q14 (0..16384), mirrored on odd quarters
  function automatic logic [14:0] quarter_pos(input logic [15:0] u);
    quarter_pos = u[14] ? 15'(15'd16384 - 15'(u[13:0])) : 15'(u[13:0]);
  endfunction

  // z^2 in q14
  function automatic logic [14:0] q14_sq(input logic [14:0] z);
    logic [29:0] zz;
    zz = 30'(z) * 30'(z);
    q14_sq = zz[28:14];
  endfunction

  // inner polynomial term 10512 - 1160*z2
  function automatic logic [13:0] sine_t(input logic [14:0] z2);
    logic [25:0] p;
    p = 26'(11'd1160) * 26'(z2);
    sine_t = 14'(14'd10512 - 14'(p[25:14]));
  endfunction

  // outer polynomial term 25736 - t*z2
  function automatic logic [14:0] sine_s(input logic [13:0] t, input logic [14:0] z2);
    logic [28:0] p;
    p = 29'(t) * 29'(z2);
    sine_s = 15'(15'd25736 - 15'(p[28:14]));
  endfunction

  // final s*z with the sign of the half wave, q14 signed
  function automatic logic signed [GrdW-1:0] sine_out(input logic [14:0] s,
                                                      input logic [14:0] z,
                                                      input logic        neg);
    logic [29:0] p;
    logic signed [GrdW-1:0] m;
    p = 30'(s) * 30'(z);
    m = $signed({1'b0, p[28:14]});
    sine_out = neg ? -m : m;
  endfunction

endpackage

// ===== rtl/core/pn2d_corner.sv =====
// one lattice corner: hash, gradient lookup and dot product, pipelined
module pn2d_corner
  import pn2d_pkg::*;
#(
  parameter int unsigned PhaseBits = 12
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [31:0]            cx_i,
  input  logic [31:0]            cy_i,
  input  logic signed [OffW-1:0] dx_i,
  input  logic signed [OffW-1:0] dy_i,
  output logic signed [DotW-1:0] dot_o
);

  // offsets wait in stages 1..7 for the gradient
  localparam int OffDly = 7;

  // stage 1: a = cx * c1
  logic [31:0] a1_q, cy1_q;
  // stage 2: b = (cy ^ rot a) * c2
  logic [31:0] a2_q, b2_q;
  // stage 3: a = (a ^ rot b) * c3
  logic [31:0] a3_q;
  // stage 4: quarter-wave position and its square
  logic [14:0] zx4_q, zy4_q, z2x4_q, z2y4_q;
  logic        nx4_q, ny4_q;
  // stage 5: inner polynomial term
  logic [14:0] zx5_q, zy5_q, z2x5_q, z2y5_q;
  logic [13:0] tpx5_q, tpy5_q;
  logic        nx5_q, ny5_q;
  // stage 6: outer polynomial term
  logic [14:0] zx6_q, zy6_q, sx6_q, sy6_q;
  logic        nx6_q, ny6_q;
  // stage 7: gradient
  logic signed [GrdW-1:0] gx7_q, gy7_q;
  // stage 8: products
  logic signed [OffW+GrdW-1:0] px8_q, py8_q;
  logic signed [OffW-1:0] dx_q [OffDly];
  logic signed [OffW-1:0] dy_q [OffDly];

  logic [15:0] u, uy;
  logic [14:0] zx, zy;
  logic signed [OffW+GrdW:0] sum;

  assign u  = 16'(a3_q >> (32 - PhaseBits)) << (16 - PhaseBits);
  assign uy = u + 16'd16384;
  assign zx = quarter_pos(u);
  assign zy = quarter_pos(uy);
  assign sum = (OffW+GrdW+1)'(px8_q) + (OffW+GrdW+1)'(py8_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= 32'(cx_i * HashMulA);
      cy1_q  <= cy_i;
      a2_q   <= a1_q;
      b2_q   <= 32'((cy1_q ^ rot16(a1_q)) * HashMulB);
      a3_q   <= 32'((a2_q ^ rot16(b2_q)) * HashMulC);
      zx4_q  <= zx;
      zy4_q  <= zy;
      z2x4_q <= q14_sq(zx);
      z2y4_q <= q14_sq(zy);
      nx4_q  <= u[15];
      ny4_q  <= uy[15];
      zx5_q  <= zx4_q;
      zy5_q  <= zy4_q;
      z2x5_q <= z2x4_q;
      z2y5_q <= z2y4_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      tpx5_q <= sine_t(z2x4_q);
      tpy5_q <= sine_t(z2y4_q);
      zx6_q  <= zx5_q;
      zy6_q  <= zy5_q;
      nx6_q  <= nx5_q;
      ny6_q  <= ny5_q;
      sx6_q  <= sine_s(tpx5_q, z2x5_q);
      sy6_q  <= sine_s(tpy5_q, z2y5_q);
      gx7_q  <= sine_out(sx6_q, zx6_q, nx6_q);
      gy7_q  <= sine_out(sy6_q, zy6_q, ny6_q);
      px8_q  <= (OffW+GrdW)'(dx_q[OffDly-1] * gx7_q);
      py8_q  <= (OffW+GrdW)'(dy_q[OffDly-1] * gy7_q);
      dot_o  <= DotW'(sum >>> 14);
      dx_q[0] <= dx_i;
      dy_q[0] <= dy_i;
      for (int k = 1; k < OffDly; k++) begin
        dx_q[k] <= dx_q[k-1];
        dy_q[k] <= dy_q[k-1];
      end
    end
  end

endmodule

// ===== rtl/core/pn2d_fade.sv =====
// quintic fade 6t^5-15t^4+10t^3 in q16, pipelined to match corner latency
module pn2d_fade
  import pn2d_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [15:0]         t_i,
  output logic [FadW-1:0]     f_o
);

  logic [15:0] t1_q;
  logic [15:0] sq1_q, cube2_q;
  logic signed [20:0] lin1_q;          // 6t - 15*65536
  logic signed [20:0] p2_q;            // quadratic term
  logic [19:0] p3_q;
  logic [15:0] cube3_q;
  logic [FadW-1:0] f4_q;
  logic [FadW-1:0] fd_q [4];           // stages 5..8

  logic signed [37:0] lt;
  logic [35:0] fp;

  assign lt = 38'(lin1_q) * 38'($signed({1'b0, t1_q}));
  assign fp = 36'(cube3_q) * 36'(p3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t_i;
      sq1_q   <= 16'((32'(t_i) * 32'(t_i)) >> 16);
      lin1_q  <= 21'(6 * $signed({5'b0, t_i})) - 21'sd983040;
      cube2_q <= 16'((32'(sq1_q) * 32'(t1_q)) >> 16);
      p2_q    <= 21'(lt >>> 16);
      cube3_q <= cube2_q;
      p3_q    <= 20'(p2_q + 21'sd655360);
      f4_q    <= FadW'(fp >> 16);
      fd_q[0] <= f4_q;
      for (int k = 1; k < 4; k++) begin
        fd_q[k] <= fd_q[k-1];
      end
      f_o     <= fd_q[3];
    end
  end

endmodule

// ===== rtl/core/perlin_noise_2d_point_top.sv =====
// top level of the 2-d gradient noise point evaluator
// depth: 13 register stages from request accept to result valid
// throughput: one request per cycle while the output is not stalled; all stages advance together
// stall: when the output register is full and not taken, the whole pipe holds
// reset: clears only the stage valid bits, data registers are not reset
module perlin_noise_2d_point_top
  import pn2d_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned PHASE_BITS      = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);

  localparam int unsigned Depth = 13;

  // pipeline advance: an empty output stage or the consumer taking the result
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // split coordinates into cell (floor) and q16 fraction
  logic [31:0] cx, cy, cx1, cy1;
  logic [15:0] tx, ty;
  logic [COORD_FRAC_BITS-1:0] frx, fry;

  assign cx = 32'(coord_x_i >>> COORD_FRAC_BITS);
  assign cy = 32'(coord_y_i >>> COORD_FRAC_BITS);
  assign cx1 = cx + 32'd1;
  assign cy1 = cy + 32'd1;
  assign frx = coord_x_i[COORD_FRAC_BITS-1:0];
  assign fry = coord_y_i[COORD_FRAC_BITS-1:0];

  if (COORD_FRAC_BITS >= 16) begin : g_trunc
    assign tx = frx[COORD_FRAC_BITS-1 -: 16];
    assign ty = fry[COORD_FRAC_BITS-1 -: 16];
  end else begin : g_ext
    assign tx = {frx, (16 - COORD_FRAC_BITS)'(0)};
    assign ty = {fry, (16 - COORD_FRAC_BITS)'(0)};
  end

  // offsets to the near and far corner
  logic signed [OffW-1:0] dx0, dy0, dx1, dy1;
  assign dx0 = $signed({2'b00, tx});
  assign dy0 = $signed({2'b00, ty});
  assign dx1 = dx0 - OffW'(65536);
  assign dy1 = dy0 - OffW'(65536);

  // four corners, stages 1..9
  logic signed [DotW-1:0] n00, n10, n01, n11;

  pn2d_corner #(.PhaseBits(PHASE_BITS)) u_c00 (
    .clk_i(clk_i), .en_i(adv), .cx_i(cx),  .cy_i(cy),  .dx_i(dx0), .dy_i(dy0), .dot_o(n00));
  pn2d_corner #(.PhaseBits(PHASE_BITS)) u_c10 (
    .clk_i(clk_i), .en_i(adv), .cx_i(cx1), .cy_i(cy),  .dx_i(dx1), .dy_i(dy0), .dot_o(n10));
  pn2d_corner #(.PhaseBits(PHASE_BITS)) u_c01 (
    .clk_i(clk_i), .en_i(adv), .cx_i(cx),  .cy_i(cy1), .dx_i(dx0), .dy_i(dy1), .dot_o(n01));
  pn2d_corner #(.PhaseBits(PHASE_BITS)) u_c11 (
    .clk_i(clk_i), .en_i(adv), .cx_i(cx1), .cy_i(cy1), .dx_i(dx1), .dy_i(dy1), .dot_o(n11));

  // fade weights, also ready after stage 9
  logic [FadW-1:0] fx6, fy6;
  pn2d_fade u_fx (.clk_i(clk_i), .en_i(adv), .t_i(tx), .f_o(fx6));
  pn2d_fade u_fy (.clk_i(clk_i), .en_i(adv), .t_i(ty), .f_o(fy6));

  // stage 10: x-lerp products, stage 11: row values
  logic signed [DotW:0] d0, d1;
  logic signed [DotW+FadW+1:0] m07_q, m17_q;
  logic signed [DotW-1:0] a07_q, a17_q;
  logic [FadW-1:0] fy7_q, fy8_q;
  logic signed [DotW:0] r08_q, r18_q;
  // stage 12: y product, stage 13: output
  logic signed [DotW+1:0] dr;
  logic signed [DotW+FadW+2:0] m9_q;
  logic signed [DotW:0] r09_q;
  logic signed [DotW+1:0] v;
  logic signed [DotW-1:0] v4;
  logic signed [15:0] out_q;

  assign d0 = (DotW+1)'(n10) - (DotW+1)'(n00);
  assign d1 = (DotW+1)'(n11) - (DotW+1)'(n01);
  assign dr = (DotW+2)'(r18_q) - (DotW+2)'(r08_q);
  assign v  = (DotW+2)'(r09_q) + (DotW+2)'(m9_q >>> 16);
  assign v4 = DotW'(v >>> 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m07_q <= (DotW+FadW+2)'(d0 * $signed({1'b0, fx6}));
      m17_q <= (DotW+FadW+2)'(d1 * $signed({1'b0, fx6}));
      a07_q <= n00;
      a17_q <= n01;
      fy7_q <= fy6;
      r08_q <= (DotW+1)'(a07_q) + (DotW+1)'(m07_q >>> 16);
      r18_q <= (DotW+1)'(a17_q) + (DotW+1)'(m17_q >>> 16);
      fy8_q <= fy7_q;
      m9_q  <= (DotW+FadW+3)'(dr * $signed({1'b0, fy8_q}));
      r09_q <= r08_q;
      // saturate to q2.14
      if (v4 > DotW'(32767))       out_q <= 16'sd32767;
      else if (v4 < -DotW'(32768)) out_q <= -16'sd32768;
      else                         out_q <= 16'(v4);
    end
  end

  assign noise_value_o = out_q;

endmodule
